FILE: rtl/hcpd_pkg.sv
// Shared widths, payload type and gain function for the heading compensation core.
`timescale 1ns / 1ps

package hcpd_pkg;

    localparam int CORDIC_STAGES_DEF = 16;

    localparam int DELTA_W     = 24;
    localparam int QUAT_W      = 16;
    localparam int WORLD_W     = 25;
    localparam int PROD_W      = 32;
    localparam int AB_W        = 34;
    localparam int VEC_SCALE   = 20;
    localparam int DELTA_GUARD = 8;
    localparam int VEC_W       = 56;
    localparam int ROT_W       = 35;
    localparam int GAIN_W      = 30;
    localparam int LO_W        = 17;
    localparam int HI_W        = ROT_W - LO_W;
    localparam int PLO_W       = LO_W + GAIN_W;
    localparam int PHI_W       = HI_W + GAIN_W + 1;
    localparam int SUM_W       = 66;
    localparam int RND_SHIFT   = 38;
    localparam int RES_W       = SUM_W - RND_SHIFT;

    localparam logic signed [AB_W-1:0]    ONE_Q28   = 34'sd268435456;
    localparam logic signed [WORLD_W-1:0] OUT_LIMIT = 25'sd11863283;

    typedef struct packed {
        logic signed [VEC_W-1:0]   vx;
        logic signed [VEC_W-1:0]   vy;
        logic signed [ROT_W-1:0]   px;
        logic signed [ROT_W-1:0]   py;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic                      bypass;
    } rot_t;

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int j = 63; j >= 0; j--)
        begin
            rem = {rem[63:0], num[j]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[j] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Inverse gain 1/K in Q30: square root of the Q60 product of the inverse squared per-stage gains
    function automatic logic [GAIN_W-1:0] gain_q30(input int n);
        logic [63:0] k2;
        logic [63:0] den;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        k2 = 64'd1 << 60;
        for (int i = 0; i < n; i++)
        begin
            den = (64'd1 << (2 * i)) + 64'd1;
            k2  = k2 - udiv64(k2, den);
        end
        v = k2;
        r = '0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++)
        begin
            if (b > v)
                b = b >> 2;
        end
        for (int j = 0; j < 32; j++)
        begin
            if (b != 64'd0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r[GAIN_W-1:0];
    endfunction

endpackage

FILE: rtl/hcpd_front.sv
// Front end: quaternion products, yaw vector forming and quarter-turn pre-rotation.
`timescale 1ns / 1ps

module hcpd_front import hcpd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [DELTA_W-1:0] delta_x,
    input  logic signed [DELTA_W-1:0] delta_y,
    input  logic signed [QUAT_W-1:0]  quat_w,
    input  logic signed [QUAT_W-1:0]  quat_x,
    input  logic signed [QUAT_W-1:0]  quat_y,
    input  logic signed [QUAT_W-1:0]  quat_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output rot_t                      out_data
);

    logic                      p0_valid_reg;
    logic signed [PROD_W-1:0]  wz_reg;
    logic signed [PROD_W-1:0]  xy_reg;
    logic signed [PROD_W-1:0]  yy_reg;
    logic signed [PROD_W-1:0]  zz_reg;
    logic signed [DELTA_W-1:0] dx_reg;
    logic signed [DELTA_W-1:0] dy_reg;
    logic                      p0_ready;
    logic                      p1_ready;
    logic                      p1_valid_reg;
    rot_t                      p1_data_reg;
    rot_t                      p1_data_next;

    logic signed [AB_W-1:0]  b_val;
    logic signed [AB_W-1:0]  a_val;
    logic signed [VEC_W-1:0] vx_a;
    logic signed [VEC_W-1:0] vy_a;
    logic signed [ROT_W-1:0] px_a;
    logic signed [ROT_W-1:0] py_a;

    assign p1_ready = !p1_valid_reg || out_ready;
    assign p0_ready = !p0_valid_reg || p1_ready;
    assign in_ready = p0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p0_valid_reg <= 1'b0;
        else if (p0_ready)
            p0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (p0_ready && in_valid)
        begin
            wz_reg <= quat_w * quat_z;
            xy_reg <= quat_x * quat_y;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            dx_reg <= delta_x;
            dy_reg <= delta_y;
        end
    end

    always_comb
    begin
        b_val = (AB_W'(wz_reg) + AB_W'(xy_reg)) <<< 1;
        a_val = ONE_Q28 - ((AB_W'(yy_reg) + AB_W'(zz_reg)) <<< 1);
        vx_a  = VEC_W'(a_val) <<< VEC_SCALE;
        vy_a  = VEC_W'(b_val) <<< VEC_SCALE;
        px_a  = ROT_W'(dx_reg) <<< DELTA_GUARD;
        py_a  = ROT_W'(dy_reg) <<< DELTA_GUARD;

        p1_data_next.vx     = vx_a;
        p1_data_next.vy     = vy_a;
        p1_data_next.px     = px_a;
        p1_data_next.py     = py_a;
        p1_data_next.dx     = dx_reg;
        p1_data_next.dy     = dy_reg;
        p1_data_next.bypass = (a_val == '0) && (b_val == '0);

        // left half plane: turn by a quarter first
        if (a_val[AB_W-1])
        begin
            if (!b_val[AB_W-1])
            begin
                p1_data_next.vx = vy_a;
                p1_data_next.vy = -vx_a;
                p1_data_next.px = -py_a;
                p1_data_next.py = px_a;
            end
            else
            begin
                p1_data_next.vx = -vy_a;
                p1_data_next.vy = vx_a;
                p1_data_next.px = py_a;
                p1_data_next.py = -px_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (p1_ready)
            p1_valid_reg <= p0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (p1_ready && p0_valid_reg)
            p1_data_reg <= p1_data_next;
    end

    assign out_valid = p1_valid_reg;
    assign out_data  = p1_data_reg;

endmodule

FILE: rtl/hcpd_cordic_stage.sv
// One CORDIC iteration: vectoring of (vx, vy) steers rotation of (px, py).
`timescale 1ns / 1ps

module hcpd_cordic_stage import hcpd_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  rot_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rot_t out_data
);

    logic                    valid_reg;
    rot_t                    data_reg;
    rot_t                    data_next;
    logic signed [VEC_W-1:0] vx_in;
    logic signed [VEC_W-1:0] vy_in;
    logic signed [ROT_W-1:0] px_in;
    logic signed [ROT_W-1:0] py_in;
    logic signed [VEC_W-1:0] svx;
    logic signed [VEC_W-1:0] svy;
    logic signed [ROT_W-1:0] spx;
    logic signed [ROT_W-1:0] spy;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        vx_in = in_data.vx;
        vy_in = in_data.vy;
        px_in = in_data.px;
        py_in = in_data.py;
        svx   = vx_in >>> SHIFT;
        svy   = vy_in >>> SHIFT;
        spx   = px_in >>> SHIFT;
        spy   = py_in >>> SHIFT;

        data_next = in_data;
        if (!vy_in[VEC_W-1])
        begin
            data_next.vx = vx_in + svy;
            data_next.vy = vy_in - svx;
            data_next.px = px_in - spy;
            data_next.py = py_in + spx;
        end
        else
        begin
            data_next.vx = vx_in - svy;
            data_next.vy = vy_in + svx;
            data_next.px = px_in + spy;
            data_next.py = py_in - spx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/hcpd_gain.sv
// Gain correction by split multiply, round to nearest, saturation and bypass select.
`timescale 1ns / 1ps

module hcpd_gain import hcpd_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  rot_t                      in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [WORLD_W-1:0] world_x,
    output logic signed [WORLD_W-1:0] world_y
);

    localparam logic [GAIN_W-1:0]       GAIN_K  = gain_q30(STAGES);
    localparam logic signed [GAIN_W:0]  GAIN_KS = {1'b0, GAIN_K};
    localparam logic signed [SUM_W-1:0] RND     = SUM_W'(1) << (RND_SHIFT - 1);
    localparam logic signed [RES_W-1:0] LIM_HI  = RES_W'(OUT_LIMIT);
    localparam logic signed [RES_W-1:0] LIM_LO  = -RES_W'(OUT_LIMIT);

    logic g1_ready;
    logic g2_ready;
    logic g3_ready;
    logic g1_valid_reg;
    logic g2_valid_reg;
    logic g3_valid_reg;

    logic signed [HI_W-1:0]    hx_in;
    logic signed [HI_W-1:0]    hy_in;
    logic [PLO_W-1:0]          plo_x_reg;
    logic [PLO_W-1:0]          plo_y_reg;
    logic signed [PHI_W-1:0]   phi_x_reg;
    logic signed [PHI_W-1:0]   phi_y_reg;
    logic signed [DELTA_W-1:0] g1_dx_reg;
    logic signed [DELTA_W-1:0] g1_dy_reg;
    logic                      g1_bypass_reg;

    logic signed [SUM_W-1:0]   sum_x_next;
    logic signed [SUM_W-1:0]   sum_y_next;
    logic signed [SUM_W-1:0]   sum_x_reg;
    logic signed [SUM_W-1:0]   sum_y_reg;
    logic signed [DELTA_W-1:0] g2_dx_reg;
    logic signed [DELTA_W-1:0] g2_dy_reg;
    logic                      g2_bypass_reg;

    logic signed [RES_W-1:0]   res_x;
    logic signed [RES_W-1:0]   res_y;
    logic signed [WORLD_W-1:0] world_x_next;
    logic signed [WORLD_W-1:0] world_y_next;
    logic signed [WORLD_W-1:0] world_x_reg;
    logic signed [WORLD_W-1:0] world_y_reg;

    assign g3_ready = !g3_valid_reg || out_ready;
    assign g2_ready = !g2_valid_reg || g3_ready;
    assign g1_ready = !g1_valid_reg || g2_ready;
    assign in_ready = g1_ready;

    assign hx_in = in_data.px[ROT_W-1:LO_W];
    assign hy_in = in_data.py[ROT_W-1:LO_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_valid_reg <= 1'b0;
            g2_valid_reg <= 1'b0;
            g3_valid_reg <= 1'b0;
        end
        else
        begin
            if (g1_ready)
                g1_valid_reg <= in_valid;
            if (g2_ready)
                g2_valid_reg <= g1_valid_reg;
            if (g3_ready)
                g3_valid_reg <= g2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (g1_ready && in_valid)
        begin
            plo_x_reg     <= in_data.px[LO_W-1:0] * GAIN_K;
            plo_y_reg     <= in_data.py[LO_W-1:0] * GAIN_K;
            phi_x_reg     <= hx_in * GAIN_KS;
            phi_y_reg     <= hy_in * GAIN_KS;
            g1_dx_reg     <= in_data.dx;
            g1_dy_reg     <= in_data.dy;
            g1_bypass_reg <= in_data.bypass;
        end
    end

    always_comb
    begin
        sum_x_next = (SUM_W'(phi_x_reg) <<< LO_W) + SUM_W'(plo_x_reg) + RND;
        sum_y_next = (SUM_W'(phi_y_reg) <<< LO_W) + SUM_W'(plo_y_reg) + RND;
    end

    always_ff @(posedge clk)
    begin
        if (g2_ready && g1_valid_reg)
        begin
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            g2_dx_reg     <= g1_dx_reg;
            g2_dy_reg     <= g1_dy_reg;
            g2_bypass_reg <= g1_bypass_reg;
        end
    end

    always_comb
    begin
        res_x = sum_x_reg[SUM_W-1:RND_SHIFT];
        res_y = sum_y_reg[SUM_W-1:RND_SHIFT];

        if (res_x > LIM_HI)
            world_x_next = OUT_LIMIT;
        else if (res_x < LIM_LO)
            world_x_next = -OUT_LIMIT;
        else
            world_x_next = res_x[WORLD_W-1:0];

        if (res_y > LIM_HI)
            world_y_next = OUT_LIMIT;
        else if (res_y < LIM_LO)
            world_y_next = -OUT_LIMIT;
        else
            world_y_next = res_y[WORLD_W-1:0];

        // degenerate heading: pass the delta through
        if (g2_bypass_reg)
        begin
            world_x_next = WORLD_W'(g2_dx_reg);
            world_y_next = WORLD_W'(g2_dy_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (g3_ready && g2_valid_reg)
        begin
            world_x_reg <= world_x_next;
            world_y_reg <= world_y_next;
        end
    end

    assign out_valid = g3_valid_reg;
    assign world_x   = world_x_reg;
    assign world_y   = world_y_reg;

endmodule

FILE: rtl/heading_compensate_planar_delta_core.sv
// Top level of the heading compensation core: front end, CORDIC pipeline, gain stage.
//
//  channel | signals                                            | direction
//  --------+----------------------------------------------------+----------
//  delta   | delta_valid, delta_stall, delta_x/y, quat_w/x/y/z  | in
//  world   | world_valid, world_stall, world_x/y                | out
//
//  One transaction per cycle sustained while world_stall is low; the path runs through
//  two front-end registers, one register per CORDIC iteration and three gain registers.
//  Each register stage holds its own valid bit; a stage loads when empty or when the next
//  stage moves, so bubbles close up and a stalled world transaction holds in place.
//  rst_n clears every valid bit asynchronously; payload registers are not reset.
`timescale 1ns / 1ps

module heading_compensate_planar_delta_core import hcpd_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      delta_valid,
    output logic                      delta_stall,
    input  logic signed [DELTA_W-1:0] delta_x,
    input  logic signed [DELTA_W-1:0] delta_y,
    input  logic signed [QUAT_W-1:0]  quat_w,
    input  logic signed [QUAT_W-1:0]  quat_x,
    input  logic signed [QUAT_W-1:0]  quat_y,
    input  logic signed [QUAT_W-1:0]  quat_z,
    output logic                      world_valid,
    input  logic                      world_stall,
    output logic signed [WORLD_W-1:0] world_x,
    output logic signed [WORLD_W-1:0] world_y
);

    logic front_ready;
    logic chain_valid [CORDIC_STAGES+1];
    logic chain_ready [CORDIC_STAGES+1];
    rot_t chain_data  [CORDIC_STAGES+1];

    assign delta_stall = !front_ready;

    hcpd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (delta_valid),
        .in_ready  (front_ready),
        .delta_x   (delta_x),
        .delta_y   (delta_y),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_stage
        hcpd_cordic_stage #(.SHIFT(g)) u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    hcpd_gain #(.STAGES(CORDIC_STAGES)) u_gain
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[CORDIC_STAGES]),
        .in_ready  (chain_ready[CORDIC_STAGES]),
        .in_data   (chain_data[CORDIC_STAGES]),
        .out_valid (world_valid),
        .out_ready (!world_stall),
        .world_x   (world_x),
        .world_y   (world_y)
    );

endmodule

FILE: rtl/hcpd_checker.sv
// Port-level checks on the heading compensation core, bound to the top level.
`timescale 1ns / 1ps

module hcpd_checker import hcpd_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      delta_valid,
    input logic                      delta_stall,
    input logic                      world_valid,
    input logic                      world_stall,
    input logic signed [WORLD_W-1:0] world_x,
    input logic signed [WORLD_W-1:0] world_y
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !world_valid)
        else $error("result valid during reset");

    a_open_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !world_stall |-> !delta_stall)
        else $error("input stalled while output side is open");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        world_valid |-> (world_x <= OUT_LIMIT) && (world_x >= -OUT_LIMIT)
                     && (world_y <= OUT_LIMIT) && (world_y >= -OUT_LIMIT))
        else $error("result beyond saturation limit");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        world_valid && world_stall |=> world_valid)
        else $error("stalled result dropped");

endmodule

bind heading_compensate_planar_delta_core hcpd_checker u_hcpd_checker (.*);

FILE: tb/world_delta_checker.sv
// Checker for the heading compensation core: predicts each world transaction and compares it.
`timescale 1ns / 1ps

module world_delta_checker import hcpd_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      delta_valid,
    input  logic                      delta_stall,
    input  logic signed [DELTA_W-1:0] delta_x,
    input  logic signed [DELTA_W-1:0] delta_y,
    input  logic signed [QUAT_W-1:0]  quat_w,
    input  logic signed [QUAT_W-1:0]  quat_x,
    input  logic signed [QUAT_W-1:0]  quat_y,
    input  logic signed [QUAT_W-1:0]  quat_z,
    input  logic                      world_valid,
    input  logic                      world_stall,
    input  logic signed [WORLD_W-1:0] world_x,
    input  logic signed [WORLD_W-1:0] world_y,
    output int                        fail_count,
    output int                        backlog
);

    localparam int N_ITER = (CORDIC_STAGES > 30) ? 30 : CORDIC_STAGES;

    typedef struct {
        logic signed [WORLD_W-1:0] wx;
        logic signed [WORLD_W-1:0] wy;
    } world_t;

    world_t world_due_q[$];
    longint gain_k;
    int     errors = 0;

    function automatic longint cordic_gain(input int n);
        longint unsigned k2;
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bitv;
        k2 = 64'd1 << 60;
        for (int i = 0; i < n; i++)
            k2 = k2 - k2 / ((64'd1 << (2 * i)) + 64'd1);
        rem  = k2;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    function automatic logic signed [WORLD_W-1:0] scale_and_clip(input longint v);
        longint r;
        r = (v * gain_k + (longint'(1) << 37)) >>> 38;
        if (r > longint'(OUT_LIMIT))
            r = longint'(OUT_LIMIT);
        if (r < -longint'(OUT_LIMIT))
            r = -longint'(OUT_LIMIT);
        return r[WORLD_W-1:0];
    endfunction

    function automatic world_t compensate_heading(
        input logic signed [DELTA_W-1:0] dx,
        input logic signed [DELTA_W-1:0] dy,
        input logic signed [QUAT_W-1:0]  qw,
        input logic signed [QUAT_W-1:0]  qx,
        input logic signed [QUAT_W-1:0]  qy,
        input logic signed [QUAT_W-1:0]  qz
    );
        longint a_q;
        longint b_q;
        longint vx;
        longint vy;
        longint px;
        longint py;
        longint t;
        longint svx;
        longint svy;
        longint spx;
        longint spy;
        world_t res;
        b_q = 2 * (longint'(qw) * longint'(qz) + longint'(qx) * longint'(qy));
        a_q = (longint'(1) << 28) - 2 * (longint'(qy) * longint'(qy) + longint'(qz) * longint'(qz));
        if (a_q == 0 && b_q == 0)
        begin
            res.wx = dx;
            res.wy = dy;
            return res;
        end
        vx = a_q * (longint'(1) << VEC_SCALE);
        vy = b_q * (longint'(1) << VEC_SCALE);
        px = longint'(dx) * (longint'(1) << DELTA_GUARD);
        py = longint'(dy) * (longint'(1) << DELTA_GUARD);
        // bring the heading vector into the right half plane by a quarter turn
        if (vx < 0)
        begin
            if (vy >= 0)
            begin
                t  = vx;
                vx = vy;
                vy = -t;
                t  = px;
                px = -py;
                py = t;
            end
            else
            begin
                t  = vx;
                vx = -vy;
                vy = t;
                t  = px;
                px = py;
                py = -t;
            end
        end
        for (int i = 0; i < N_ITER; i++)
        begin
            svx = vx >>> i;
            svy = vy >>> i;
            spx = px >>> i;
            spy = py >>> i;
            if (vy >= 0)
            begin
                vx = vx + svy;
                vy = vy - svx;
                px = px - spy;
                py = py + spx;
            end
            else
            begin
                vx = vx - svy;
                vy = vy + svx;
                px = px + spy;
                py = py - spx;
            end
        end
        res.wx = scale_and_clip(px);
        res.wy = scale_and_clip(py);
        return res;
    endfunction

    initial
        gain_k = cordic_gain(N_ITER);

    always @(posedge clk)
    begin
        world_t due;
        if (rst_n)
        begin
            if (world_valid && !world_stall)
            begin
                if (world_due_q.size() == 0)
                begin
                    $error("world transaction with nothing pending: world_x %0d world_y %0d",
                           world_x, world_y);
                    errors++;
                end
                else
                begin
                    due = world_due_q.pop_front();
                    if (world_x !== due.wx)
                    begin
                        $error("world_x mismatch: expected %0d, actual %0d", due.wx, world_x);
                        errors++;
                    end
                    if (world_y !== due.wy)
                    begin
                        $error("world_y mismatch: expected %0d, actual %0d", due.wy, world_y);
                        errors++;
                    end
                end
            end
            if (delta_valid && !delta_stall)
                world_due_q.push_back(compensate_heading(delta_x, delta_y,
                                                         quat_w, quat_x, quat_y, quat_z));
        end
        fail_count <= errors;
        backlog    <= world_due_q.size();
    end

endmodule

FILE: tb/testbench.sv
// Top of the heading compensation testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import hcpd_pkg::*;

    localparam int STAGES      = CORDIC_STAGES_DEF;
    localparam int N_RANDOM    = 1900;
    localparam int CYCLE_LIMIT = 300000;
    localparam int CALM_FIRST  = 800;
    localparam int CALM_LAST   = 1100;

    localparam logic signed [DELTA_W-1:0] D_MAX = 24'sh7FFFFF;
    localparam logic signed [DELTA_W-1:0] D_MIN = 24'sh800000;
    localparam logic signed [QUAT_W-1:0]  Q_ONE = 16'sd16384;
    localparam logic signed [QUAT_W-1:0]  Q_C45 = 16'sd11585;
    localparam logic signed [QUAT_W-1:0]  Q_C22 = 16'sd15137;
    localparam logic signed [QUAT_W-1:0]  Q_S22 = 16'sd6270;
    localparam logic signed [QUAT_W-1:0]  Q_HLF = 16'sd8192;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      delta_valid;
    logic                      delta_stall;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic signed [QUAT_W-1:0]  quat_w;
    logic signed [QUAT_W-1:0]  quat_x;
    logic signed [QUAT_W-1:0]  quat_y;
    logic signed [QUAT_W-1:0]  quat_z;
    logic                      world_valid;
    logic                      world_stall;
    logic signed [WORLD_W-1:0] world_x;
    logic signed [WORLD_W-1:0] world_y;
    logic                      calm;
    int                        hold_left;
    int                        fail_count;
    int                        backlog;
    int                        cycle_count = 0;

    heading_compensate_planar_delta_core #(.CORDIC_STAGES(STAGES)) dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .delta_valid (delta_valid),
        .delta_stall (delta_stall),
        .delta_x     (delta_x),
        .delta_y     (delta_y),
        .quat_w      (quat_w),
        .quat_x      (quat_x),
        .quat_y      (quat_y),
        .quat_z      (quat_z),
        .world_valid (world_valid),
        .world_stall (world_stall),
        .world_x     (world_x),
        .world_y     (world_y)
    );

    world_delta_checker #(.CORDIC_STAGES(STAGES)) u_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .delta_valid (delta_valid),
        .delta_stall (delta_stall),
        .delta_x     (delta_x),
        .delta_y     (delta_y),
        .quat_w      (quat_w),
        .quat_x      (quat_x),
        .quat_y      (quat_y),
        .quat_z      (quat_z),
        .world_valid (world_valid),
        .world_stall (world_stall),
        .world_x     (world_x),
        .world_y     (world_y),
        .fail_count  (fail_count),
        .backlog     (backlog)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_stall <= 1'b0;
            hold_left   <= 0;
        end
        else if (calm)
        begin
            world_stall <= 1'b0;
            hold_left   <= 0;
        end
        else if (hold_left > 0)
        begin
            world_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end
        else if ($urandom_range(0, 199) == 0)
        begin
            world_stall <= 1'b1;
            hold_left   <= $urandom_range(5, 40);
        end
        else
        begin
            world_stall <= ($urandom_range(0, 99) < 21);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic send_motion(
        input logic signed [DELTA_W-1:0] dx,
        input logic signed [DELTA_W-1:0] dy,
        input logic signed [QUAT_W-1:0]  qw,
        input logic signed [QUAT_W-1:0]  qx,
        input logic signed [QUAT_W-1:0]  qy,
        input logic signed [QUAT_W-1:0]  qz,
        input bit                        may_idle
    );
        delta_valid <= 1'b1;
        delta_x     <= dx;
        delta_y     <= dy;
        quat_w      <= qw;
        quat_x      <= qx;
        quat_y      <= qy;
        quat_z      <= qz;
        @(posedge clk);
        while (delta_stall)
            @(posedge clk);
        if (may_idle)
        begin
            if ($urandom_range(0, 199) == 0)
            begin
                delta_valid <= 1'b0;
                repeat ($urandom_range(5, 40))
                    @(posedge clk);
            end
            else
            begin
                while ($urandom_range(0, 99) < 21)
                begin
                    delta_valid <= 1'b0;
                    @(posedge clk);
                end
            end
        end
    endtask

    initial
    begin
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic signed [QUAT_W-1:0]  qw;
        logic signed [QUAT_W-1:0]  qx;
        logic signed [QUAT_W-1:0]  qy;
        logic signed [QUAT_W-1:0]  qz;
        bit                        quiet;

        rst_n       <= 1'b0;
        calm        <= 1'b0;
        delta_valid <= 1'b0;
        delta_x     <= '0;
        delta_y     <= '0;
        quat_w      <= '0;
        quat_x      <= '0;
        quat_y      <= '0;
        quat_z      <= '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_motion(24'sd0, 24'sd0, Q_ONE, 16'sd0, 16'sd0, 16'sd0, 1'b1);
        send_motion(D_MAX, D_MAX, Q_ONE, 16'sd0, 16'sd0, 16'sd0, 1'b1);
        send_motion(D_MIN, D_MIN, Q_ONE, 16'sd0, 16'sd0, 16'sd0, 1'b1);
        send_motion(D_MAX, 24'sd0, Q_C45, 16'sd0, 16'sd0, Q_C45, 1'b1);
        send_motion(24'sd1, -24'sd1, 16'sd0, 16'sd0, 16'sd0, Q_ONE, 1'b1);
        send_motion(D_MAX, D_MIN, -16'sd1, 16'sd0, 16'sd0, Q_ONE, 1'b1);
        send_motion(24'sd0, D_MAX, Q_C45, 16'sd0, 16'sd0, -Q_C45, 1'b1);
        send_motion(D_MAX, D_MAX, Q_C22, 16'sd0, 16'sd0, Q_S22, 1'b1);
        send_motion(D_MIN, D_MIN, Q_C22, 16'sd0, 16'sd0, Q_S22, 1'b1);
        send_motion(D_MIN, D_MAX, Q_S22, 16'sd0, 16'sd0, Q_C22, 1'b1);
        send_motion(24'sd12345, -24'sd54321, 16'sd0, 16'sd0, Q_HLF, Q_HLF, 1'b1);
        send_motion(D_MAX, D_MIN, 16'sd1000, -16'sd1000, Q_HLF, Q_HLF, 1'b1);
        send_motion(D_MIN, 24'sd1, -16'sd77, -16'sd77, -Q_HLF, Q_HLF, 1'b1);
        send_motion(24'sd4096, 24'sd8192, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
        send_motion(D_MAX, D_MAX, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        send_motion(D_MIN, D_MAX, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
        send_motion(24'sd1000, 24'sd2000, 16'sd0, Q_ONE, Q_ONE, 16'sd0, 1'b1);
        send_motion(-24'sd3000, 24'sd700, 16'sd0, Q_ONE, 16'sd0, 16'sd0, 1'b1);
        send_motion(-24'sd1, 24'sd1, Q_ONE, 16'sd0, 16'sd0, 16'sd1, 1'b1);
        send_motion(D_MAX, D_MIN, -Q_ONE, 16'sd0, 16'sd0, 16'sd0, 1'b1);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            quiet = (n >= CALM_FIRST && n < CALM_LAST);
            calm <= quiet;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    qw = 16'(int'($urandom_range(0, 32768)) - 16384);
                    qx = 16'(int'($urandom_range(0, 32768)) - 16384);
                    qy = 16'(int'($urandom_range(0, 32768)) - 16384);
                    qz = 16'(int'($urandom_range(0, 32768)) - 16384);
                end
                5:
                begin
                    qw = 16'($urandom);
                    qx = 16'($urandom);
                    qy = 16'($urandom);
                    qz = 16'($urandom);
                end
                6:
                begin
                    qw = 16'(int'($urandom_range(0, 32768)) - 16384);
                    qy = $urandom_range(0, 1) ? Q_HLF : -Q_HLF;
                    qz = $urandom_range(0, 1) ? Q_HLF : -Q_HLF;
                    qx = (qy == qz) ? -qw : qw;
                end
                7:
                begin
                    qx = 16'sd0;
                    qy = 16'sd0;
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            qw = Q_ONE;
                            qz = 16'sd0;
                        end
                        1:
                        begin
                            qw = 16'sd0;
                            qz = Q_ONE;
                        end
                        2:
                        begin
                            qw = Q_C45;
                            qz = Q_C45;
                        end
                        default:
                        begin
                            qw = Q_C45;
                            qz = -Q_C45;
                        end
                    endcase
                end
                8:
                begin
                    qw = 16'(int'($urandom_range(0, 6)) - 3);
                    qx = 16'sd0;
                    qy = 16'sd0;
                    qz = $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
                end
                default:
                begin
                    qw = 16'(int'($urandom_range(0, 6)) - 3);
                    qx = 16'(int'($urandom_range(0, 6)) - 3);
                    qy = 16'(int'($urandom_range(0, 6)) - 3);
                    qz = 16'(int'($urandom_range(0, 6)) - 3);
                end
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    dx = 24'($urandom);
                    dy = 24'($urandom);
                end
                6, 7:
                begin
                    dx = 24'(int'($urandom_range(0, 2000)) - 1000);
                    dy = 24'(int'($urandom_range(0, 2000)) - 1000);
                end
                8:
                begin
                    dx = $urandom_range(0, 1) ? D_MAX : D_MIN;
                    dy = $urandom_range(0, 1) ? D_MAX : D_MIN;
                end
                default:
                begin
                    dx = D_MAX - 24'($urandom_range(0, 4095));
                    dy = D_MIN + 24'($urandom_range(0, 4095));
                end
            endcase
            send_motion(dx, dy, qw, qx, qy, qz, !quiet);
        end

        delta_valid <= 1'b0;
        calm        <= 1'b0;
        do
            @(posedge clk);
        while (backlog != 0);
        repeat (STAGES + 10)
            @(posedge clk);
        if (fail_count == 0 && backlog == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
rtl/hcpd_pkg.sv
rtl/hcpd_front.sv
rtl/hcpd_cordic_stage.sv
rtl/hcpd_gain.sv
rtl/heading_compensate_planar_delta_core.sv
rtl/hcpd_checker.sv
tb/world_delta_checker.sv
tb/testbench.sv
